// ===== rtl/ers_pkg.sv =====
// Shared types and constants for the edge ratio statistics table.
package ers_pkg;

	localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

	typedef enum logic [1:0] {
		KIND_UPDATE = 2'd0,
		KIND_SET    = 2'd1,
		KIND_READ   = 2'd2,
		KIND_BEST   = 2'd3
	} ers_kind_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RMW,
		ST_SCAN,
		ST_DONE
	} ers_state_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [4:0]  edge_index;
		logic [2:0]  first_code;
		logic [2:0]  second_code;
		logic [31:0] ratio_in;
		logic        same_beginning;
	} ers_in_t;

	typedef struct packed {
		logic [2:0]  result_first;
		logic [2:0]  result_second;
		logic [31:0] result_value;
	} ers_out_t;

endpackage

// ===== rtl/edge_ratio_stats_table.sv =====
// Edge ratio statistics table: top level with control, scan logic and the ratio store.
// Update, set and read pass through ST_RMW and then ST_DONE after acceptance; an out-of-range
// item goes straight to ST_DONE; a best search walks ST_SCAN, one store read per code pair.
// The result is registered into the output on leaving ST_DONE. One transaction in flight: the
// next is accepted only back in ST_IDLE, after any wait for the output register to drain. After
// reset the store is swept to zero, one entry a cycle, with in_ready low.
module edge_ratio_stats_table #(
	parameter int TREE_HEIGHT = 4,
	parameter int NUM_CODES   = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  ers_pkg::ers_in_t  in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output ers_pkg::ers_out_t out_data
);
	import ers_pkg::*;

	localparam int EDGE_COUNT = (1 << (TREE_HEIGHT + 1)) - 2;
	localparam int ROWS       = (EDGE_COUNT < 32) ? EDGE_COUNT : 32;
	localparam int EW         = $clog2(ROWS);
	localparam int CW         = $clog2(NUM_CODES);
	localparam int PW         = 2 * CW;
	localparam int DEPTH      = ROWS << PW;
	localparam int AW         = $clog2(DEPTH);

	ers_state_t      state_q, state_d;
	ers_in_t         item_q;
	ers_out_t        res_q, out_q;
	logic            out_valid_q;
	logic [AW-1:0]   clr_q;
	logic [PW:0]     cnt_q;
	logic [PW-1:0]   pair_s1;
	logic            scan_v_s1;
	logic [31:0]     best_q;
	logic [2:0]      bf_q, bs_q;

	logic            accept, out_free;
	logic            edge_ok_in, slot_ok_in, is_best_in;
	logic [AW-1:0]   in_addr, item_addr, scan_addr;
	logic            ram_we, ram_re;
	logic [AW-1:0]   ram_waddr, ram_raddr;
	logic [31:0]     ram_wdata, ram_rdata;
	logic [31:0]     old_fl, new_fl, rmw_val;
	logic [32:0]     sum;
	logic [CW-1:0]   scan_a, scan_b;
	logic            qualify;

	assign accept     = in_valid && in_ready;
	assign out_free   = !out_valid_q || out_ready;
	assign is_best_in = (in_data.kind == KIND_BEST);
	assign edge_ok_in = ({27'd0, in_data.edge_index} < 32'(EDGE_COUNT));
	assign slot_ok_in = edge_ok_in
		&& ({29'd0, in_data.first_code} < 32'(NUM_CODES))
		&& ({29'd0, in_data.second_code} < 32'(NUM_CODES));

	assign in_addr   = AW'({EW'(in_data.edge_index), CW'(in_data.first_code),
		CW'(in_data.second_code)});
	assign item_addr = AW'({EW'(item_q.edge_index), CW'(item_q.first_code),
		CW'(item_q.second_code)});
	assign scan_addr = AW'({EW'(item_q.edge_index), cnt_q[PW-1:0]});

	assign old_fl  = (ram_rdata < ONE_Q16) ? ONE_Q16 : ram_rdata;
	assign new_fl  = (item_q.ratio_in < ONE_Q16) ? ONE_Q16 : item_q.ratio_in;
	assign sum     = {1'b0, old_fl} + {1'b0, new_fl};

	always_comb begin
		unique case (item_q.kind)
			KIND_UPDATE: rmw_val = sum[32:1];
			KIND_SET:    rmw_val = item_q.ratio_in;
			default:     rmw_val = ram_rdata;
		endcase
	end

	assign scan_a  = pair_s1[PW-1:CW];
	assign scan_b  = pair_s1[CW-1:0];
	assign qualify = scan_v_s1
		&& (32'(scan_b) != 32'(item_q.second_code))
		&& (!item_q.same_beginning || (32'(scan_a) == 32'(item_q.first_code)))
		&& (ram_rdata > best_q);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_q == AW'(DEPTH - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) begin
					if (is_best_in) state_d = edge_ok_in ? ST_SCAN : ST_DONE;
					else            state_d = slot_ok_in ? ST_RMW : ST_DONE;
				end
			end
			ST_RMW: state_d = ST_DONE;
			ST_SCAN: begin
				if (cnt_q[PW] && !scan_v_s1) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	// outputs and store control
	always_comb begin
		in_ready  = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = clr_q;
		ram_wdata = '0;
		ram_re    = 1'b0;
		ram_raddr = in_addr;
		unique case (state_q)
			ST_CLEAR: begin
				ram_we = 1'b1;
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				ram_re   = in_valid && !is_best_in && slot_ok_in;
			end
			ST_RMW: begin
				ram_waddr = item_addr;
				ram_wdata = rmw_val;
				ram_we    = (item_q.kind == KIND_UPDATE) || (item_q.kind == KIND_SET);
			end
			ST_SCAN: begin
				ram_raddr = scan_addr;
				ram_re    = !cnt_q[PW];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			cnt_q       <= '0;
			scan_v_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + AW'(1);
			if (accept) cnt_q <= '0;
			else if (state_q == ST_SCAN && !cnt_q[PW]) cnt_q <= cnt_q + (PW+1)'(1);
			scan_v_s1 <= (state_q == ST_SCAN) && !cnt_q[PW];
			if (state_q == ST_DONE && out_free) out_valid_q <= 1'b1;
			else if (out_ready)                 out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		pair_s1 <= cnt_q[PW-1:0];
		if (accept) begin
			item_q <= in_data;
			best_q <= ONE_Q16;
			bf_q   <= in_data.first_code;
			bs_q   <= '0;
			res_q  <= '{result_first: in_data.first_code,
				result_second: is_best_in ? 3'd0 : in_data.second_code,
				result_value: is_best_in ? ONE_Q16 : 32'd0};
		end else if (qualify) begin
			best_q <= ram_rdata;
			bf_q   <= 3'(scan_a);
			bs_q   <= 3'(scan_b);
		end
		if (state_q == ST_RMW) begin
			res_q <= '{result_first: item_q.first_code, result_second: item_q.second_code,
				result_value: rmw_val};
		end else if (state_q == ST_SCAN && state_d == ST_DONE) begin
			res_q <= '{result_first: bf_q, result_second: bs_q, result_value: best_q};
		end
		if (state_q == ST_DONE && out_free) out_q <= res_q;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	ers_ram #(
		.WIDTH(32),
		.DEPTH(DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);
endmodule

// ===== rtl/ers_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module ers_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1920
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
